>>> rtl/core/uniform_sample_chi_square_moment_test_top_macros.svh
// assertion macros for the uniformity test block
`ifndef UNIFORM_SAMPLE_CHI_SQUARE_MOMENT_TEST_TOP_MACROS_SVH
`define UNIFORM_SAMPLE_CHI_SQUARE_MOMENT_TEST_TOP_MACROS_SVH
// implication checked at every clock edge outside reset
`define USC_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// implication checked on the clock after the antecedent
`define USC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

>>> rtl/core/usc_pkg.sv
// shared types and constants of the uniformity test block
package usc_pkg;
  localparam int Bins = 10;
  localparam int Moments = 5;
  localparam int MaxSamples = 65536;
  localparam int BinW = $clog2(Bins);
  localparam int MomW = (Moments > 1) ? $clog2(Moments) : 1;
  localparam int Entries = Bins + Moments;
  localparam int AddrW = $clog2(Entries);
  localparam logic [0:0] CfgCritical = 1'b0;
  localparam logic [0:0] CfgThreshold = 1'b1;

  // expected moment 65536/(k+1) for k = 1..8, lowest order in the low bits
  localparam logic [8*16-1:0] ExpMoments = {
    16'(65536 / 9), 16'(65536 / 8), 16'(65536 / 7), 16'(65536 / 6),
    16'(65536 / 5), 16'(65536 / 4), 16'(65536 / 3), 16'(65536 / 2)
  };

  typedef enum logic [2:0] {
    StIdle, StClear, StSq, StDiv, StMom, StEmit, StWipe
  } state_e;

  typedef struct packed {
    logic        we;
    logic [AddrW-1:0] waddr;
    logic [31:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // expected moment 65536/(k+1), k = index+1
  function automatic logic [15:0] expect_moment(input logic [MomW-1:0] idx);
    return ExpMoments[16*idx +: 16];
  endfunction
endpackage

>>> rtl/core/uniform_sample_chi_square_moment_test_top.sv
// top level of the chi-squared uniformity and moments test
//  channel  | signals                          | direction
//  sample   | sample_valid_i/ready_o, 2 fields | in
//  result   | result_valid_o/ready_i, 10 fields| out
//  config   | cfg_we_i, cfg_index_i, cfg_data_i| in
// a sample is accepted, then a read and a write for the bin and for each
// power, formed one multiply per power; past MaxSamples it is not counted.
// a last sample then runs squares over the bins (the last starts the chi
// division), the 48 chi division steps and per moment a read, then 48
// division steps, then each result word is read and offered, and a wipe pass
// over all Entries words. after reset a wipe pass over all Entries words runs
// before the first sample. a stalled result holds the sequencer.
module uniform_sample_chi_square_moment_test_top import usc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sample_valid_i,
  output logic        sample_ready_o,
  input  logic [15:0] sample_i,
  input  logic        last_sample_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic        item_kind_o,
  output logic [5:0]  item_index_o,
  output logic [16:0] bin_count_o,
  output logic [15:0] moment_value_o,
  output logic [15:0] moment_difference_o,
  output logic        moment_pass_o,
  output logic [31:0] chi_squared_o,
  output logic        frequency_pass_o,
  output logic        all_moments_pass_o,
  output logic        last_result_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  `include "uniform_sample_chi_square_moment_test_top_macros.svh"

  state_e state_q, state_d;
  logic [31:0] crit_q;
  logic [15:0] thr_q;
  logic [16:0] total_q, total_d;
  logic [15:0] r_q, r_d;
  logic        last_q, last_d;
  logic [15:0] pow_q, pow_d;
  logic [3:0]  step_q, step_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [39:0] sq_q, sq_d;
  logic [31:0] chi_q, chi_d;
  logic [15:0] mval_q [Moments];
  logic [Moments-1:0] mpass;
  logic        mset;
  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic        rd_wait_q, rd_wait_d;
  logic [31:0] rdata;
  logic [31:0] prod;
  logic [47:0] nn;
  logic        phase_q, phase_d;
  mem_req_t    req;
  logic [15:0] binv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= 32'd4331; thr_q <= 16'd655;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgCritical) crit_q <= cfg_data_i;
      else thr_q <= cfg_data_i[15:0];
    end
  end

  usc_store u_store (.clk_i, .req_i(req), .rdata_o(rdata));
  usc_divider u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                     .den_i(total_q), .done_o(div_done), .quo_o(div_quo));

  assign binv = 16'((32'(r_q) * 32'(Bins)) >> 16);
  assign prod = 32'(pow_q) * 32'(r_q);
  assign nn   = 48'(total_q) * 48'(total_q);

  // sequencer
  always_comb begin
    state_d = state_q; total_d = total_q; r_d = r_q; last_d = last_q;
    pow_d = pow_q; step_d = step_q; ptr_d = ptr_q; sq_d = sq_q; chi_d = chi_q;
    rd_wait_d = 1'b0; phase_d = phase_q;
    req = '0; div_start = 1'b0; div_num = '0; mset = 1'b0;
    sample_ready_o = 1'b0; result_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        sample_ready_o = 1'b1;
        if (sample_valid_i) begin
          r_d = sample_i; last_d = last_sample_i; pow_d = sample_i;
          step_d = '0; phase_d = 1'b0;
          if (total_q < 17'(MaxSamples)) begin
            state_d = StClear; total_d = total_q + 17'd1;
          end else begin
            state_d = StSq; ptr_d = '0; sq_d = '0;
            if (!last_sample_i) state_d = StIdle;
          end
        end
      end
      // read-modify-write: phase 0 issues read, phase 1 writes back
      StClear: begin
        if (step_q == 4'd0) req.raddr = (binv >= 16'(Bins)) ?
                                       AddrW'(Bins - 1) : AddrW'(binv);
        else req.raddr = AddrW'(Bins) + AddrW'(step_q - 4'd1);
        if (!phase_q) phase_d = 1'b1;
        else begin
          phase_d = 1'b0;
          req.we = 1'b1; req.waddr = req.raddr;
          if (step_q == 4'd0) req.wdata = {15'd0, rdata[16:0] + 17'd1};
          else begin
            req.wdata = rdata + 32'(pow_q);
            pow_d = prod[31:16];
          end
          step_d = step_q + 4'd1;
          if (step_q == 4'(Moments)) begin
            state_d = last_q ? StSq : StIdle; ptr_d = '0; sq_d = '0;
            rd_wait_d = 1'b0;
          end
        end
      end
      // sum of squared counts, read pipelined one ahead
      StSq: begin
        req.raddr = ptr_q;
        rd_wait_d = 1'b1;
        if (rd_wait_q) sq_d = sq_q + 40'(rdata[16:0]) * 40'(rdata[16:0]);
        if (ptr_q == AddrW'(Bins)) begin
          state_d = StDiv; step_d = '0;
          div_start = 1'b1;
          div_num = (48'(sq_d) * 48'(Bins) > nn) ? 48'({(48'(sq_d) * 48'(Bins) - nn), 8'd0}) : '0;
        end else ptr_d = ptr_q + AddrW'(1);
      end
      // chi then moments through the shared divider
      StDiv: begin
        req.raddr = AddrW'(Bins) + AddrW'(step_q);
        if (div_done) begin
          if (step_q == 4'd0 && !phase_q) begin
            chi_d = (total_q == 0) ? 32'd0 :
                    (div_quo[47:32] != 0) ? 32'hFFFF_FFFF : div_quo[31:0];
            phase_d = 1'b1; state_d = StMom;
          end else begin
            mset = 1'b1;
            step_d = step_q + 4'd1;
            state_d = (step_q == 4'(Moments - 1)) ? StEmit : StMom;
            ptr_d = '0;
          end
        end
      end
      StMom: begin
        req.raddr = AddrW'(Bins) + AddrW'(step_q);
        rd_wait_d = 1'b1;
        if (rd_wait_q) begin
          div_start = 1'b1; div_num = 48'(rdata); state_d = StDiv;
        end
      end
      StEmit: begin
        req.raddr = ptr_q;
        rd_wait_d = 1'b1;
        result_valid_o = rd_wait_q;
        if (rd_wait_q && result_ready_i) begin
          rd_wait_d = 1'b0;
          if (ptr_q == AddrW'(Entries - 1)) begin
            state_d = StWipe; ptr_d = '0;
          end else ptr_d = ptr_q + AddrW'(1);
        end
      end
      StWipe: begin
        req.we = 1'b1; req.waddr = ptr_q;
        total_d = '0;
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_q == AddrW'(Entries - 1)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StWipe; ptr_q <= '0; total_q <= '0; rd_wait_q <= 1'b0;
      phase_q <= 1'b0; step_q <= '0;
    end else begin
      state_q <= state_d; ptr_q <= ptr_d; total_q <= total_d;
      rd_wait_q <= rd_wait_d; phase_q <= phase_d; step_q <= step_d;
    end
  end
  always_ff @(posedge clk_i) begin
    r_q <= r_d; last_q <= last_d; pow_q <= pow_d; sq_q <= sq_d; chi_q <= chi_d;
    if (mset) begin
      mval_q[step_q[MomW-1:0]] <= (total_q == 0) ? 16'd0 : div_quo[15:0];
    end
  end

  // moment pass flags, formed while emitting is not needed: computed per index
  always_comb begin
    for (int i = 0; i < Moments; i++) begin
      logic [15:0] e, d;
      e = expect_moment(MomW'(i));
      d = (e > mval_q[i]) ? e - mval_q[i] : mval_q[i] - e;
      mpass[i] = d < thr_q;
    end
  end

  // result word fields
  always_comb begin
    item_kind_o = ptr_q >= AddrW'(Bins);
    item_index_o = item_kind_o ? 6'(ptr_q - AddrW'(Bins)) : 6'(ptr_q);
    bin_count_o = item_kind_o ? 17'd0 : rdata[16:0];
    moment_value_o = item_kind_o ? mval_q[item_index_o[MomW-1:0]] : 16'd0;
    moment_difference_o = '0;
    moment_pass_o = 1'b0;
    if (item_kind_o) begin
      moment_difference_o = (expect_moment(item_index_o[MomW-1:0]) > moment_value_o) ?
        expect_moment(item_index_o[MomW-1:0]) - moment_value_o :
        moment_value_o - expect_moment(item_index_o[MomW-1:0]);
      moment_pass_o = mpass[item_index_o[MomW-1:0]];
    end
    chi_squared_o = chi_q;
    frequency_pass_o = chi_q < crit_q;
    all_moments_pass_o = &mpass;
    last_result_o = ptr_q == AddrW'(Entries - 1);
  end

  `USC_ASSERT(a_no_overlap, result_valid_o, !sample_ready_o, "result while taking samples")
  `USC_ASSERT_NEXT(a_hold, result_valid_o && !result_ready_i, result_valid_o, "result dropped")
  `USC_ASSERT(a_cap, 1'b1, total_q <= 17'(MaxSamples), "sample count overflow")
endmodule

>>> rtl/core/usc_divider.sv
// restoring divider, one quotient bit per cycle
module usc_divider import usc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [47:0] quo_o
);
  logic [47:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [17:0] trial;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q[16:0], quo_q[47]};
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = 6'd48; busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[46:0], 1'b0};
      rem_d = trial;
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d[0] = 1'b1;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
  end
  assign quo_o = {quo_d[47:1], quo_d[0]};
endmodule

>>> rtl/core/usc_store.sv
// accumulator memory: bin counts then power sums, one read one write port
module usc_store import usc_pkg::*; (
  input  logic        clk_i,
  input  mem_req_t    req_i,
  output logic [31:0] rdata_o
);
  logic [31:0] mem_q [Entries];
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

>>> bench/usc_checker.sv
// checker for the uniformity test block: predicts result words and compares them
module usc_checker import usc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sample_valid_i,
  input  logic        sample_ready_i,
  input  logic [15:0] sample_i,
  input  logic        last_sample_i,
  input  logic        result_valid_i,
  input  logic        result_ready_i,
  input  logic        item_kind_i,
  input  logic [5:0]  item_index_i,
  input  logic [16:0] bin_count_i,
  input  logic [15:0] moment_value_i,
  input  logic [15:0] moment_difference_i,
  input  logic        moment_pass_i,
  input  logic [31:0] chi_squared_i,
  input  logic        frequency_pass_i,
  input  logic        all_moments_pass_i,
  input  logic        last_result_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  typedef struct packed {
    logic        kind;
    logic [5:0]  index;
    logic [16:0] count;
    logic [15:0] mval;
    logic [15:0] mdif;
    logic        mpass;
    logic [31:0] chi;
    logic        fpass;
    logic        allpass;
    logic        last;
  } result_t;

  result_t     expected_q[$];
  logic [31:0] crit_limit;
  logic [15:0] mom_limit;
  logic [16:0] bin_tally [Bins];
  logic [31:0] power_acc [Moments];
  logic [16:0] sample_cnt;

  assign pending_o = expected_q.size();

  // one line per mismatch
  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors_o++;
  endtask

  // bin count and power sums for one sample
  task automatic tally_sample(input logic [15:0] r);
    int unsigned bin;
    logic [31:0] p;
    if (sample_cnt >= MaxSamples) return;
    bin = (32'(r) * Bins) >> 16;
    if (bin >= Bins) bin = Bins - 1;
    bin_tally[bin] = bin_tally[bin] + 1;
    p = 32'(r);
    for (int k = 0; k < Moments; k++) begin
      if (k > 0) p = 32'((64'(p) * 64'(r)) >> 16);
      power_acc[k] = power_acc[k] + p;
    end
    sample_cnt = sample_cnt + 1;
  endtask

  // evaluate the set and queue its result words
  task automatic evaluate_set();
    logic [63:0] n, sq, lhs, nn, q;
    logic [31:0] chi, ev, m;
    logic [15:0] mv [Moments];
    logic [15:0] md [Moments];
    logic        mp [Moments];
    logic        allp;
    result_t     w;
    n = 64'(sample_cnt);
    sq = 0;
    chi = 0;
    allp = 1;
    for (int i = 0; i < Bins; i++) sq += 64'(bin_tally[i]) * 64'(bin_tally[i]);
    lhs = sq * Bins;
    nn = n * n;
    if (n != 0 && lhs > nn) begin
      q = ((lhs - nn) << 8) / n;
      chi = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    for (int i = 0; i < Moments; i++) begin
      ev = 65536 / (i + 2);
      m = (n != 0) ? 32'(64'(power_acc[i]) / n) : 0;
      m = m & 32'hFFFF;
      mv[i] = m[15:0];
      md[i] = (ev > m) ? 16'(ev - m) : 16'(m - ev);
      mp[i] = md[i] < mom_limit;
      if (!mp[i]) allp = 0;
    end
    for (int i = 0; i < Entries; i++) begin
      w = '0;
      w.kind = (i >= Bins);
      w.index = w.kind ? 6'(i - Bins) : 6'(i);
      if (!w.kind) w.count = bin_tally[i];
      else begin
        w.mval = mv[i - Bins];
        w.mdif = md[i - Bins];
        w.mpass = mp[i - Bins];
      end
      w.chi = chi;
      w.fpass = chi < crit_limit;
      w.allpass = allp;
      w.last = (i == Entries - 1);
      expected_q.insert(expected_q.size(), w);
    end
    foreach (bin_tally[i]) bin_tally[i] = 0;
    foreach (power_acc[i]) power_acc[i] = 0;
    sample_cnt = 0;
  endtask

  // watch the three ports
  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    if (!rst_ni) begin
      crit_limit <= 32'd4331;
      mom_limit <= 16'd655;
      foreach (bin_tally[i]) bin_tally[i] = 0;
      foreach (power_acc[i]) power_acc[i] = 0;
      sample_cnt = 0;
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgCritical) crit_limit <= cfg_data_i;
        else if (cfg_index_i == CfgThreshold) mom_limit <= cfg_data_i[15:0];
      end
      if (sample_valid_i && sample_ready_i) begin
        tally_sample(sample_i);
        if (last_sample_i) evaluate_set();
      end
      if (result_valid_i && result_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("mismatch: result word with nothing expected");
          errors_o++;
        end else begin
          w = expected_q.pop_front();
          if (item_kind_i != w.kind) report("item_kind", item_kind_i, w.kind);
          if (item_index_i != w.index) report("item_index", item_index_i, w.index);
          if (bin_count_i != w.count) report("bin_count", bin_count_i, w.count);
          if (moment_value_i != w.mval) report("moment_value", moment_value_i, w.mval);
          if (moment_difference_i != w.mdif)
            report("moment_difference", moment_difference_i, w.mdif);
          if (moment_pass_i != w.mpass) report("moment_pass", moment_pass_i, w.mpass);
          if (chi_squared_i != w.chi) report("chi_squared", chi_squared_i, w.chi);
          if (frequency_pass_i != w.fpass)
            report("frequency_pass", frequency_pass_i, w.fpass);
          if (all_moments_pass_i != w.allpass)
            report("all_moments_pass", all_moments_pass_i, w.allpass);
          if (last_result_i != w.last) report("last_result", last_result_i, w.last);
        end
      end
    end
  end
endmodule

>>> bench/tb.sv
// stimulus and verdict for the uniformity test block
module tb import usc_pkg::*;;
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        sample_valid_i = 0;
  logic        sample_ready_o;
  logic [15:0] sample_i = 0;
  logic        last_sample_i = 0;
  logic        result_valid_o;
  logic        result_ready_i = 0;
  logic        item_kind_o;
  logic [5:0]  item_index_o;
  logic [16:0] bin_count_o;
  logic [15:0] moment_value_o;
  logic [15:0] moment_difference_o;
  logic        moment_pass_o;
  logic [31:0] chi_squared_o;
  logic        frequency_pass_o;
  logic        all_moments_pass_o;
  logic        last_result_o;
  logic        cfg_we_i = 0;
  logic [0:0]  cfg_index_i = CfgCritical;
  logic [31:0] cfg_data_i = 0;
  int          errors;
  int          pending;
  bit          calm = 0;
  bit          hold_off = 0;
  int          idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  uniform_sample_chi_square_moment_test_top dut (.*);
  usc_checker chk (
    .clk_i, .rst_ni, .sample_valid_i, .sample_ready_i(sample_ready_o), .sample_i,
    .last_sample_i, .result_valid_i(result_valid_o), .result_ready_i, .item_kind_i(item_kind_o),
    .item_index_i(item_index_o), .bin_count_i(bin_count_o), .moment_value_i(moment_value_o),
    .moment_difference_i(moment_difference_o), .moment_pass_i(moment_pass_o),
    .chi_squared_i(chi_squared_o), .frequency_pass_i(frequency_pass_o),
    .all_moments_pass_i(all_moments_pass_o), .last_result_i(last_result_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .errors_o(errors), .pending_o(pending));

  // receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (hold_off) result_ready_i <= 0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        result_ready_i <= 0;
        repeat (burst) @(posedge clk_i);
        result_ready_i <= 1;
      end else result_ready_i <= 1;
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((sample_valid_i && sample_ready_o) || (result_valid_o && result_ready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one sample word through the handshake, with an optional gap before it
  task automatic send_sample(input logic [15:0] r, input logic lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      sample_valid_i <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    sample_valid_i <= 1;
    sample_i <= r;
    last_sample_i <= lst;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  task automatic drain();
    sample_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    drain();
    repeat (400) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // a set of random samples, mostly uniform
  task automatic random_set(input int len);
    for (int i = 0; i < len; i++)
      send_sample(16'($urandom_range(0, 65535)), i == len - 1);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: field extremes, bin boundaries, single sample set
    send_sample(16'h0000, 0);
    send_sample(16'hFFFF, 0);
    send_sample(16'h8000, 0);
    send_sample(16'h1999, 0);
    send_sample(16'h199A, 0);
    send_sample(16'h5555, 0);
    send_sample(16'hAAAA, 1);
    send_sample(16'hFFFF, 1);
    send_sample(16'h0000, 1);
    for (int i = 0; i < 10; i++) send_sample(16'(i * 6554 + 100), i == 9);
    // sender pause until all results are out
    drain();
    // extremes of the registers
    write_reg(CfgCritical, 32'hFFFF_FFFF);
    write_reg(CfgThreshold, 32'h0000_FFFF);
    random_set(12);
    write_reg(CfgCritical, 32'd0);
    write_reg(CfgThreshold, 32'hFFFF_0000);
    random_set(8);
    write_reg(CfgCritical, 32'd1200);
    write_reg(CfgThreshold, 32'd3000);
    // long receiver hold-off while samples keep coming
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        random_set(4);
        random_set(4);
        random_set(6);
      end
    join
    drain();
    write_reg(CfgCritical, 32'd4331);
    write_reg(CfgThreshold, 32'd655);
    // random sets, some skewed to a narrow range
    for (int s = 0; s < 12; s++) begin
      if (s == 9) calm = 1;
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 10; i++)
          send_sample(16'($urandom_range(0, 4095) | ($urandom_range(0, 1) << 15)), i == 9);
      end else random_set($urandom_range(3, 20));
    end
    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/usc_pkg.sv
rtl/core/usc_divider.sv
rtl/core/usc_store.sv
rtl/core/uniform_sample_chi_square_moment_test_top.sv
bench/usc_checker.sv
bench/tb.sv
